// ----- design/tce_pkg.sv -----
// Package for the text console engine: beat types, mode and character codes,
// and the fixed cell constants. No dependencies.
`timescale 1ns / 1ps

package tce_pkg;

  localparam logic [2:0] MODE_PUT   = 3'd0;
  localparam logic [2:0] MODE_DRAW  = 3'd1;
  localparam logic [2:0] MODE_SET   = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_HIDE  = 3'd4;
  localparam logic [2:0] MODE_SHOW  = 3'd5;
  localparam logic [2:0] MODE_CLEAR = 3'd6;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_BS = 8'h08;

  localparam logic [7:0] SPACE_CHAR  = 8'h20;
  localparam logic [7:0] CLEAR_COLOR = 8'h07;
  localparam logic [7:0] MAX_COLOR   = 8'h8F;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] color;
  } tce_in_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic       cursor_hidden;
    logic       error;
  } tce_out_t;

endpackage

// ----- design/tce_cell_ram.sv -----
// Cell store: one write port and one read port, read data registered.
// Standalone; sized by the top level.
`timescale 1ns / 1ps

module tce_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tce_ctrl.sv -----
// Sequencer of the text console engine: cursor, command decode, scroll copy
// and blanking sweeps over the cell store. Depends on tce_pkg.
`timescale 1ns / 1ps

module tce_ctrl import tce_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  parameter int unsigned CELLS   = ROWS * COLUMNS,
  parameter int unsigned AW      = $clog2(CELLS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tce_in_t       cmd_i,
  input  logic [7:0]    text_color_i,
  output logic          done_o,
  output tce_out_t      res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [15:0]   mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [15:0]   mem_rdata_i
);

  localparam int unsigned CW = $clog2(CELLS + 1);
  localparam logic [CW-1:0] CELLS_C   = CW'(CELLS);
  localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);
  localparam logic [CW-1:0] ROW_BASE  = CW'((ROWS - 1) * COLUMNS);
  localparam logic [4:0]    LAST_ROW  = 5'(ROWS - 1);
  localparam logic [6:0]    LAST_COL  = 7'(COLUMNS - 1);
  localparam logic [5:0]    ROWS_CMP  = 6'(ROWS);
  localparam logic [7:0]    COLS_CMP  = 8'(COLUMNS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_BLANK  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  tce_in_t       cmd_q;
  logic [4:0]    row_q, row_d;
  logic [6:0]    col_q, col_d;
  logic          hid_q, hid_d;
  logic          err_q, err_d;
  logic [7:0]    rd_q, rd_d;
  logic          done_q, done_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic          rv_q, rv_d;
  logic          report_q, report_d;

  logic [CW-1:0] cur_lin, cmd_lin, lin_back, ptr_back;
  logic          cmd_inside, accept;

  assign accept     = start_i && (state_q == S_IDLE);
  assign busy_o     = (state_q != S_IDLE);
  assign cur_lin    = CW'(row_q) * COLS_C + CW'(col_q);
  assign cmd_lin    = CW'(cmd_q.row) * COLS_C + CW'(cmd_q.col);
  assign lin_back   = cur_lin - CW'(1);
  assign ptr_back   = ptr_q - COLS_C;
  assign cmd_inside = ({1'b0, cmd_q.row} < ROWS_CMP) && ({1'b0, cmd_q.col} < COLS_CMP);

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    hid_d       = hid_q;
    err_d       = err_q;
    rd_d        = rd_q;
    done_d      = 1'b0;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    rv_d        = rv_q;
    report_d    = report_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        err_d   = 1'b0;
        rd_d    = '0;
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (cmd_q.mode)
          MODE_PUT: begin
            case (cmd_q.char_code)
              CH_LF: begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  state_d  = S_SCROLL;
                  done_d   = 1'b0;
                  ptr_d    = COLS_C;
                  rv_d     = 1'b0;
                  report_d = 1'b1;
                end else begin
                  row_d = row_q + 5'd1;
                end
              end
              CH_CR: begin
                col_d = '0;
              end
              CH_BS: begin
                if (cur_lin != '0) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = lin_back[AW-1:0];
                  mem_wdata_o = {text_color_i, SPACE_CHAR};
                  if (col_q == '0) begin
                    row_d = row_q - 5'd1;
                    col_d = LAST_COL;
                  end else begin
                    col_d = col_q - 7'd1;
                  end
                end
              end
              default: begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cur_lin[AW-1:0];
                mem_wdata_o = {text_color_i, cmd_q.char_code};
                if (row_q == LAST_ROW && col_q == LAST_COL) begin
                  col_d    = '0;
                  state_d  = S_SCROLL;
                  done_d   = 1'b0;
                  ptr_d    = COLS_C;
                  rv_d     = 1'b0;
                  report_d = 1'b1;
                end else if (col_q == LAST_COL) begin
                  row_d = row_q + 5'd1;
                  col_d = '0;
                end else begin
                  col_d = col_q + 7'd1;
                end
              end
            endcase
          end
          MODE_DRAW: begin
            if (cmd_inside) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = cmd_lin[AW-1:0];
              mem_wdata_o = {cmd_q.color, cmd_q.char_code};
            end else begin
              err_d = 1'b1;
            end
          end
          MODE_SET: begin
            if (cmd_inside) begin
              row_d = cmd_q.row;
              col_d = cmd_q.col;
            end else begin
              err_d = 1'b1;
            end
          end
          MODE_READ: begin
            if (cmd_inside) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = cmd_lin[AW-1:0];
              state_d     = S_READ;
              done_d      = 1'b0;
            end else begin
              err_d = 1'b1;
            end
          end
          MODE_HIDE: begin
            hid_d = 1'b1;
          end
          MODE_SHOW: begin
            hid_d = 1'b0;
          end
          MODE_CLEAR: begin
            row_d    = '0;
            col_d    = '0;
            state_d  = S_BLANK;
            done_d   = 1'b0;
            ptr_d    = '0;
            report_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        rd_d    = mem_rdata_i[7:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCROLL: begin
        if (rv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wptr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (ptr_q != CELLS_C) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q[AW-1:0];
          ptr_d       = ptr_q + CW'(1);
          wptr_d      = ptr_back[AW-1:0];
          rv_d        = 1'b1;
        end else begin
          rv_d    = 1'b0;
          ptr_d   = ROW_BASE;
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q[AW-1:0];
        mem_wdata_o = {CLEAR_COLOR, SPACE_CHAR};
        if (ptr_q == CELLS_C - CW'(1)) begin
          state_d = S_IDLE;
          done_d  = report_q;
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_BLANK;
      row_q    <= '0;
      col_q    <= '0;
      hid_q    <= 1'b0;
      err_q    <= 1'b0;
      rd_q     <= '0;
      done_q   <= 1'b0;
      ptr_q    <= '0;
      rv_q     <= 1'b0;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      col_q    <= col_d;
      hid_q    <= hid_d;
      err_q    <= err_d;
      rd_q     <= rd_d;
      done_q   <= done_d;
      ptr_q    <= ptr_d;
      rv_q     <= rv_d;
      report_q <= report_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wptr_q <= wptr_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign done_o              = done_q;
  assign res_o.read_char     = rd_q;
  assign res_o.cursor_row    = row_q;
  assign res_o.cursor_col    = col_q;
  assign res_o.cursor_hidden = hid_q;
  assign res_o.error         = err_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result beat outside idle");
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, row_q} < ROWS_CMP) && ({1'b0, col_q} < COLS_CMP))
    else $error("cursor out of range");
  a_scroll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL && mem_we_o && mem_re_o) |-> mem_waddr_o < mem_raddr_o)
    else $error("scroll write overtakes read");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted beat not executed");
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> CW'(mem_waddr_o) < CELLS_C)
    else $error("cell write out of range");
`endif

endmodule

// ----- design/text_console_engine.sv -----
// Text console engine top level: text color register, sequencer and cell store.
// Depends on tce_pkg, tce_ctrl and tce_cell_ram.
//
// A command beat is taken when start is high and busy is low; its single result
// appears on res_o for one cycle with done_o high and cannot be held off. Most
// commands pass through the command register and the result register; a cell
// read also passes through the cell store's registered read port. A newline on
// the last row, or a printed byte on the last cell, scrolls: one cell copy per
// cycle, then a last-row blank. Clear blanks every cell. After reset the block
// sweeps the store to blanks with busy high and no result. Text color writes are
// taken at any time; a value above MAX_COLOR is ignored.
`timescale 1ns / 1ps

module text_console_engine import tce_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  tce_in_t    cmd_i,
  output logic       done_o,
  output tce_out_t   res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [7:0]    text_color_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= CLEAR_COLOR;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_data_i <= MAX_COLOR)) begin
      text_color_q <= cfg_data_i;
    end
  end

  tce_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .AW      (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .cmd_i        (cmd_i),
    .text_color_i (text_color_q),
    .done_o       (done_o),
    .res_o        (res_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tce_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
